/* rtl/ilse_pkg.sv */
package ilse_pkg;

    // Default sizes for the list
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths at the ports
    localparam int OP_W    = 4;
    localparam int IDX_W   = 4;
    localparam int VALUE_W = 32;
    localparam int READ_W  = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT  = 4'd0,
        OP_PUSH_BACK   = 4'd1,
        OP_INSERT_AT   = 4'd2,
        OP_ERASE_FRONT = 4'd3,
        OP_ERASE_BACK  = 4'd4,
        OP_ERASE_AT    = 4'd5,
        OP_WRITE       = 4'd6,
        OP_READ        = 4'd7,
        OP_CLEAR       = 4'd8,
        OP_READ_FRONT  = 4'd9,
        OP_READ_BACK   = 4'd10
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // What the row of cells does on this edge
    typedef enum logic [1:0] {
        ROW_HOLD   = 2'd0,
        ROW_INSERT = 2'd1,
        ROW_ERASE  = 2'd2,
        ROW_WRITE  = 2'd3
    } row_op_t;

    typedef struct packed {
        row_op_t op;      // shift/load command for the cells
        logic    take;    // result carries the word at pos
        status_t status;
    } row_cmd_t;

endpackage

/* rtl/ilse_cell.sv */
module ilse_cell #(
    parameter int DEPTH      = ilse_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ilse_pkg::DATA_WIDTH_DEF,
    parameter int IDX        = 0
) (
    input  logic                         clk,
    input  ilse_pkg::row_cmd_t           cmd,
    input  logic [$clog2(DEPTH)-1:0]     pos,
    input  logic [DATA_WIDTH-1:0]        value,
    input  logic [DATA_WIDTH-1:0]        lower_data,
    input  logic [DATA_WIDTH-1:0]        upper_data,
    output logic [DATA_WIDTH-1:0]        data
);

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] MY_POS = IW'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.op)
            ilse_pkg::ROW_INSERT:
            begin
                if (MY_POS == pos)
                    data_next = value;
                else if (MY_POS > pos)
                    data_next = lower_data;   // move up one place
            end
            ilse_pkg::ROW_ERASE:
            begin
                if (MY_POS >= pos)
                    data_next = upper_data;   // move down one place
            end
            ilse_pkg::ROW_WRITE:
            begin
                if (MY_POS == pos)
                    data_next = value;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* rtl/ilse_ctrl.sv */
module ilse_ctrl #(
    parameter int DEPTH = ilse_pkg::DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic [ilse_pkg::OP_W-1:0]      op,
    input  logic [ilse_pkg::IDX_W-1:0]     index,
    output ilse_pkg::row_cmd_t             cmd,
    output logic [$clog2(DEPTH)-1:0]       pos,
    output logic [$clog2(DEPTH+1)-1:0]     count_next
);

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > ilse_pkg::IDX_W) ? CW : ilse_pkg::IDX_W;

    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_calc;
    logic [CW-1:0]   cnt_m1;
    logic [CMPW-1:0] idx_ext;
    logic [CMPW-1:0] cnt_ext;
    logic            full;
    logic            empty;
    logic [IW-1:0]   idx_pos;
    logic [IW-1:0]   last_pos;
    logic [IW-1:0]   tail_pos;
    ilse_pkg::row_cmd_t dec;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign cnt_m1   = count_reg - CW'(1);
    assign idx_ext  = CMPW'(index);
    assign cnt_ext  = CMPW'(count_reg);
    assign idx_pos  = idx_ext[IW-1:0];
    assign last_pos = cnt_m1[IW-1:0];
    assign tail_pos = count_reg[IW-1:0];

    always_comb
    begin
        dec        = '{op: ilse_pkg::ROW_HOLD, take: 1'b0, status: ilse_pkg::ST_OK};
        pos        = '0;
        count_calc = count_reg;
        unique case (ilse_pkg::op_t'(op))
            ilse_pkg::OP_PUSH_FRONT, ilse_pkg::OP_PUSH_BACK:
            begin
                if (full)
                    dec.status = ilse_pkg::ST_FULL;
                else
                begin
                    dec.op     = ilse_pkg::ROW_INSERT;
                    pos        = (ilse_pkg::op_t'(op) == ilse_pkg::OP_PUSH_FRONT) ? '0 : tail_pos;
                    count_calc = count_reg + CW'(1);
                end
            end
            ilse_pkg::OP_INSERT_AT:
            begin
                // range check wins over the full check
                if (idx_ext > cnt_ext)
                    dec.status = ilse_pkg::ST_RANGE;
                else if (full)
                    dec.status = ilse_pkg::ST_FULL;
                else
                begin
                    dec.op     = ilse_pkg::ROW_INSERT;
                    pos        = idx_pos;
                    count_calc = count_reg + CW'(1);
                end
            end
            ilse_pkg::OP_ERASE_FRONT, ilse_pkg::OP_ERASE_BACK:
            begin
                if (empty)
                    dec.status = ilse_pkg::ST_EMPTY;
                else
                begin
                    dec.op     = ilse_pkg::ROW_ERASE;
                    dec.take   = 1'b1;
                    pos        = (ilse_pkg::op_t'(op) == ilse_pkg::OP_ERASE_FRONT) ? '0 : last_pos;
                    count_calc = cnt_m1;
                end
            end
            ilse_pkg::OP_ERASE_AT:
            begin
                if (idx_ext >= cnt_ext)
                    dec.status = ilse_pkg::ST_RANGE;
                else
                begin
                    dec.op     = ilse_pkg::ROW_ERASE;
                    dec.take   = 1'b1;
                    pos        = idx_pos;
                    count_calc = cnt_m1;
                end
            end
            ilse_pkg::OP_WRITE:
            begin
                if (idx_ext >= cnt_ext)
                    dec.status = ilse_pkg::ST_RANGE;
                else
                begin
                    dec.op = ilse_pkg::ROW_WRITE;
                    pos    = idx_pos;
                end
            end
            ilse_pkg::OP_READ:
            begin
                if (idx_ext >= cnt_ext)
                    dec.status = ilse_pkg::ST_RANGE;
                else
                begin
                    dec.take = 1'b1;
                    pos      = idx_pos;
                end
            end
            ilse_pkg::OP_CLEAR:
            begin
                count_calc = '0;
            end
            ilse_pkg::OP_READ_FRONT, ilse_pkg::OP_READ_BACK:
            begin
                if (empty)
                    dec.status = ilse_pkg::ST_EMPTY;
                else
                begin
                    dec.take = 1'b1;
                    pos      = (ilse_pkg::op_t'(op) == ilse_pkg::OP_READ_FRONT) ? '0 : last_pos;
                end
            end
            default:
            begin
                // unused codes: no change, ok status
                count_calc = count_reg;
            end
        endcase
    end

    always_comb
    begin
        cmd = dec;
        if (!fire)
            cmd.op = ilse_pkg::ROW_HOLD;
    end

    assign count_next = count_calc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (fire)
            count_reg <= count_calc;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(count_reg))
        else $error("entry count moved without an item");

    a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        fire && dec.status != ilse_pkg::ST_OK |=> count_reg == $past(count_reg))
        else $error("rejected item changed the count");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && dec.op == ilse_pkg::ROW_INSERT |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the count by one");

endmodule

/* rtl/indexed_list_shift_engine_core.sv */
// Latency: a result is valid in the cycle after its item is accepted (one register).
// Throughput: one item per cycle unless a result is stalled; every cell shifts, loads or holds on the same edge.
// in_ready is high while the output register is empty or is being taken this cycle,
// so a stalled result holds back the next item.
// Reset clears the entry count and the output valid; cell words are not reset.
module indexed_list_shift_engine_core #(
    parameter int DEPTH      = ilse_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ilse_pkg::DATA_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // item in
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ilse_pkg::OP_W-1:0]       op,
    input  logic [ilse_pkg::IDX_W-1:0]      index,
    input  logic [ilse_pkg::VALUE_W-1:0]    value,
    // result out
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ilse_pkg::READ_W-1:0]     read_data,
    output logic [1:0]                      status,
    output logic [ilse_pkg::COUNT_W-1:0]    count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                       fire;
    ilse_pkg::row_cmd_t         cmd;
    logic [IW-1:0]              pos;
    logic [CW-1:0]              count_next;
    logic [DATA_WIDTH-1:0]      value_w;
    logic [DATA_WIDTH-1:0]      cell_data [DEPTH];
    logic [DATA_WIDTH-1:0]      sel_word;

    // output register
    logic                           out_valid_reg;
    logic [ilse_pkg::READ_W-1:0]    read_data_reg;
    ilse_pkg::status_t              status_reg;
    logic [ilse_pkg::COUNT_W-1:0]   count_out_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    // input word trimmed or widened to the stored width
    assign value_w = DATA_WIDTH'(value);

    ilse_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .op         (op),
        .index      (index),
        .cmd        (cmd),
        .pos        (pos),
        .count_next (count_next)
    );

    // Row of cells: cell g holds list entry g. Inserts pull from the lower
    // neighbor, erases pull from the upper one. The end cells feed themselves.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] lower_w;
        logic [DATA_WIDTH-1:0] upper_w;

        if (g == 0)
        begin : g_first
            assign lower_w = cell_data[0];
        end
        else
        begin : g_mid_lo
            assign lower_w = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign upper_w = cell_data[DEPTH-1];
        end
        else
        begin : g_mid_hi
            assign upper_w = cell_data[g+1];
        end

        ilse_cell #(
            .DEPTH      (DEPTH),
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (g)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .pos        (pos),
            .value      (value_w),
            .lower_data (lower_w),
            .upper_data (upper_w),
            .data       (cell_data[g])
        );
    end

    // Read and removed words both come from the cell at pos before this edge
    assign sel_word = cmd.take ? cell_data[pos] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            read_data_reg <= ilse_pkg::READ_W'(sel_word);
            status_reg    <= cmd.status;
            count_out_reg <= ilse_pkg::COUNT_W'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign status    = status_reg;
    assign count     = count_out_reg;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    // Self-checking bench for the indexed list engine.
    // Each accepted item is run through a local copy of the list; the expected result
    // is queued and compared with the next result the block hands out.

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 11;
    localparam int LIST_DEPTH    = ilse_pkg::DEPTH_DEF;
    localparam int IDLE_LIMIT    = 1000;   // cycles with no handshake on either side
    localparam int DRAIN_CYCLES  = 4;      // one-register latency, plus margin
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 310;

    typedef logic [ilse_pkg::OP_W-1:0]  opcode_t;
    typedef logic [ilse_pkg::IDX_W-1:0] index_t;

    // op codes the block ignores
    localparam logic [ilse_pkg::OP_W-1:0] OP_SPARE_FIRST = 4'd11;
    localparam logic [ilse_pkg::OP_W-1:0] OP_SPARE_LAST  = 4'd15;

    localparam logic [ilse_pkg::VALUE_W-1:0] WORD_ONES = '1;
    localparam logic [ilse_pkg::VALUE_W-1:0] WORD_ZERO = '0;

    typedef struct {
        logic [ilse_pkg::READ_W-1:0]  data;
        ilse_pkg::status_t            st;
        logic [ilse_pkg::COUNT_W-1:0] cnt;
    } list_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [ilse_pkg::OP_W-1:0]      op;
    logic [ilse_pkg::IDX_W-1:0]     index;
    logic [ilse_pkg::VALUE_W-1:0]   value;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [ilse_pkg::READ_W-1:0]    read_data;
    logic [1:0]                     status;
    logic [ilse_pkg::COUNT_W-1:0]   count;

    // local copy of the list, updated as each item is accepted
    logic [ilse_pkg::DATA_WIDTH_DEF-1:0] shadow_words [LIST_DEPTH];
    int                                  shadow_count = 0;

    list_result_t pending_results [$];

    // sender / receiver pacing
    int           gap_max    = 0;
    int           burst_max  = 1;
    int           burst_left = 0;
    logic [15:0]  stall_pattern = '1;
    logic [3:0]   stall_pos = '0;
    bit           grow_mode = 1'b1;

    // bookkeeping
    int error_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int full_results    = 0;
    int idle_cycles     = 0;
    int reject_count [4] = '{0, 0, 0, 0};

    indexed_list_shift_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .index     (index),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data),
        .status    (status),
        .count     (count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // List predictor
    // ------------------------------------------------------------------

    // Move entries at and above pos up one place.
    function automatic void open_slot(input int pos);
        int i;
        for (i = shadow_count; i > pos; i--)
            shadow_words[i] = shadow_words[i - 1];
    endfunction

    // Remove the entry at pos, close the hole, return the removed word.
    function automatic logic [ilse_pkg::READ_W-1:0] close_slot(input int pos);
        logic [ilse_pkg::READ_W-1:0] word;
        int                          i;
        word = shadow_words[pos];
        for (i = pos; i + 1 < shadow_count; i++)
            shadow_words[i] = shadow_words[i + 1];
        shadow_count--;
        return word;
    endfunction

    function automatic list_result_t apply_list_op(input logic [ilse_pkg::OP_W-1:0] opc,
                                                   input logic [ilse_pkg::IDX_W-1:0] idx,
                                                   input logic [ilse_pkg::VALUE_W-1:0] val);
        list_result_t res;
        int           pos;
        bit           full;
        bit           empty;
        res.data = '0;
        res.st   = ilse_pkg::ST_OK;
        full     = (shadow_count >= LIST_DEPTH);
        empty    = (shadow_count == 0);
        case (opc)
            ilse_pkg::OP_PUSH_FRONT, ilse_pkg::OP_PUSH_BACK:
            begin
                if (full)
                    res.st = ilse_pkg::ST_FULL;
                else
                begin
                    pos = (opc == ilse_pkg::OP_PUSH_FRONT) ? 0 : shadow_count;
                    open_slot(pos);
                    shadow_words[pos] = val;
                    shadow_count++;
                end
            end
            ilse_pkg::OP_INSERT_AT:
            begin
                // range is checked ahead of full
                if (int'(idx) > shadow_count)
                    res.st = ilse_pkg::ST_RANGE;
                else if (full)
                    res.st = ilse_pkg::ST_FULL;
                else
                begin
                    open_slot(int'(idx));
                    shadow_words[idx] = val;
                    shadow_count++;
                end
            end
            ilse_pkg::OP_ERASE_FRONT, ilse_pkg::OP_ERASE_BACK:
            begin
                if (empty)
                    res.st = ilse_pkg::ST_EMPTY;
                else
                    res.data = close_slot((opc == ilse_pkg::OP_ERASE_FRONT) ?
                                          0 : shadow_count - 1);
            end
            ilse_pkg::OP_ERASE_AT:
            begin
                if (int'(idx) >= shadow_count)
                    res.st = ilse_pkg::ST_RANGE;
                else
                    res.data = close_slot(int'(idx));
            end
            ilse_pkg::OP_WRITE:
            begin
                if (int'(idx) >= shadow_count)
                    res.st = ilse_pkg::ST_RANGE;
                else
                    shadow_words[idx] = val;
            end
            ilse_pkg::OP_READ:
            begin
                if (int'(idx) >= shadow_count)
                    res.st = ilse_pkg::ST_RANGE;
                else
                    res.data = shadow_words[idx];
            end
            ilse_pkg::OP_CLEAR:
                shadow_count = 0;
            ilse_pkg::OP_READ_FRONT, ilse_pkg::OP_READ_BACK:
            begin
                if (empty)
                    res.st = ilse_pkg::ST_EMPTY;
                else
                    res.data = shadow_words[(opc == ilse_pkg::OP_READ_FRONT) ?
                                            0 : shadow_count - 1];
            end
            default:
                ;   // spare codes: no effect
        endcase
        res.cnt = shadow_count[ilse_pkg::COUNT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check results, predict accepted items, watchdog.
    // Everything is sampled at the rising edge; inputs move on the falling one.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        list_result_t want;
        bit           took_in;
        bit           took_out;
        if (rst_n)
        begin
            took_out = out_valid && out_ready;
            took_in  = in_valid && in_ready;

            // a result leaving now belongs to an item accepted on an earlier edge
            if (took_out)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result: read_data=%h status=%0d count=%0d",
                             $time, read_data, status, count);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_checked++;
                    reject_count[want.st]++;
                    if (want.cnt == LIST_DEPTH)
                        full_results++;
                    if (read_data !== want.data)
                    begin
                        $display("%0t: read_data mismatch: expected %h, actual %h",
                                 $time, want.data, read_data);
                        error_count++;
                    end
                    if (status !== want.st)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.st, status);
                        error_count++;
                    end
                    if (count !== want.cnt)
                    begin
                        $display("%0t: count mismatch: expected %0d, actual %0d",
                                 $time, want.cnt, count);
                        error_count++;
                    end
                end
            end

            if (took_in)
                pending_results.insert(pending_results.size(),
                                       apply_list_op(op, index, value));

            if (took_in || took_out)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, pending_results.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver: ready follows a rotating 16-bit pattern, never all zero.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready = 1'b0;
        else
        begin
            out_ready = stall_pattern[stall_pos];
            stall_pos = stall_pos + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender: one item per call, in bursts with random gaps.
    // Valid stays high across back-to-back items; it only drops for a gap.
    // ------------------------------------------------------------------
    task automatic send_list_op(input logic [ilse_pkg::OP_W-1:0] opc,
                                input logic [ilse_pkg::IDX_W-1:0] idx,
                                input logic [ilse_pkg::VALUE_W-1:0] val);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            burst_left = (gap_max == 0) ? 1 : $urandom_range(1, burst_max);
        end
        burst_left--;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        op       = opc;
        index    = idx;
        value    = val;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Pacing per phase: 0 none, 1 sender gaps, 2 receiver stalls, then both.
    task automatic set_idling(input int phase);
        burst_left = 0;
        case (phase)
            0:
            begin
                gap_max       = 0;
                stall_pattern = '1;
            end
            1:
            begin
                gap_max       = $urandom_range(1, 12);
                burst_max     = $urandom_range(1, 8);
                stall_pattern = '1;
            end
            2:
            begin
                gap_max       = 0;
                stall_pattern = 16'($urandom_range(1, 16'hFFFF));
            end
            default:
            begin
                gap_max       = $urandom_range(1, 20);
                burst_max     = $urandom_range(1, 16);
                stall_pattern = 16'($urandom_range(1, 16'hFFFF));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Random item shaping
    // ------------------------------------------------------------------

    // Growing phases favor pushes and inserts, shrinking ones favor erases.
    function automatic logic [ilse_pkg::OP_W-1:0] pick_list_op(input bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 97)
            return opcode_t'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        if (r == 96 || (!grow && r >= 94))
            return ilse_pkg::OP_CLEAR;
        if (grow)
        begin
            if (r < 18) return ilse_pkg::OP_PUSH_FRONT;
            if (r < 36) return ilse_pkg::OP_PUSH_BACK;
            if (r < 54) return ilse_pkg::OP_INSERT_AT;
            if (r < 59) return ilse_pkg::OP_ERASE_FRONT;
            if (r < 64) return ilse_pkg::OP_ERASE_BACK;
            if (r < 70) return ilse_pkg::OP_ERASE_AT;
            if (r < 78) return ilse_pkg::OP_WRITE;
            if (r < 88) return ilse_pkg::OP_READ;
            if (r < 92) return ilse_pkg::OP_READ_FRONT;
            return ilse_pkg::OP_READ_BACK;
        end
        if (r < 6)  return ilse_pkg::OP_PUSH_FRONT;
        if (r < 12) return ilse_pkg::OP_PUSH_BACK;
        if (r < 18) return ilse_pkg::OP_INSERT_AT;
        if (r < 34) return ilse_pkg::OP_ERASE_FRONT;
        if (r < 50) return ilse_pkg::OP_ERASE_BACK;
        if (r < 68) return ilse_pkg::OP_ERASE_AT;
        if (r < 76) return ilse_pkg::OP_WRITE;
        if (r < 86) return ilse_pkg::OP_READ;
        if (r < 90) return ilse_pkg::OP_READ_FRONT;
        return ilse_pkg::OP_READ_BACK;
    endfunction

    // Mostly in range, often right at the boundary, sometimes anywhere.
    function automatic logic [ilse_pkg::IDX_W-1:0] pick_index(
        input logic [ilse_pkg::OP_W-1:0] opc);
        int r;
        int top;
        int pick;
        r   = $urandom_range(0, 99);
        top = (opc == ilse_pkg::OP_INSERT_AT) ? shadow_count : shadow_count - 1;
        if (r < 15)
            pick = $urandom_range(0, LIST_DEPTH - 1);
        else if (r < 30 || top < 0)
            pick = shadow_count;
        else
            pick = $urandom_range(0, top);
        if (pick > LIST_DEPTH - 1)
            pick = LIST_DEPTH - 1;
        return pick[ilse_pkg::IDX_W-1:0];
    endfunction

    function automatic logic [ilse_pkg::VALUE_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return WORD_ZERO;
        if (r < 16)
            return WORD_ONES;
        return $urandom;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every read, erase and indexed op against an empty list.
    task automatic test_empty_list();
        send_list_op(ilse_pkg::OP_READ_FRONT, 4'd0, WORD_ZERO);
        send_list_op(ilse_pkg::OP_READ_BACK, 4'd0, WORD_ZERO);
        send_list_op(ilse_pkg::OP_ERASE_FRONT, 4'd0, WORD_ZERO);
        send_list_op(ilse_pkg::OP_ERASE_BACK, 4'd0, WORD_ZERO);
        send_list_op(ilse_pkg::OP_ERASE_AT, 4'd0, WORD_ZERO);
        send_list_op(ilse_pkg::OP_WRITE, 4'd15, WORD_ONES);
        send_list_op(ilse_pkg::OP_READ, 4'd0, WORD_ZERO);
        send_list_op(ilse_pkg::OP_INSERT_AT, 4'd1, WORD_ONES);   // past count
        send_list_op(OP_SPARE_LAST, 4'd15, WORD_ONES);           // ignored
    endtask

    // Fill to capacity, hit the full cases, then work on the full list.
    task automatic test_full_list();
        int i;
        send_list_op(ilse_pkg::OP_INSERT_AT, 4'd0, WORD_ZERO);   // index == count appends
        send_list_op(ilse_pkg::OP_PUSH_BACK, 4'd0, WORD_ONES);
        for (i = 0; i < LIST_DEPTH - 2; i++)
        begin
            case (i % 3)
                0: send_list_op(ilse_pkg::OP_PUSH_FRONT, index_t'($urandom), $urandom);
                1: send_list_op(ilse_pkg::OP_PUSH_BACK, index_t'($urandom), $urandom);
                default: send_list_op(ilse_pkg::OP_INSERT_AT,
                                      index_t'($urandom_range(0, i + 2)), $urandom);
            endcase
        end
        send_list_op(ilse_pkg::OP_PUSH_FRONT, 4'd0, WORD_ONES);
        send_list_op(ilse_pkg::OP_PUSH_BACK, 4'd0, WORD_ONES);
        send_list_op(ilse_pkg::OP_INSERT_AT, 4'd7, WORD_ONES);   // in range but full
        send_list_op(ilse_pkg::OP_READ_BACK, 4'd0, WORD_ZERO);
        send_list_op(ilse_pkg::OP_ERASE_AT, 4'd15, WORD_ZERO);   // last entry
        send_list_op(ilse_pkg::OP_INSERT_AT, 4'd15, WORD_ONES);  // append back to full
        send_list_op(ilse_pkg::OP_WRITE, 4'd0, WORD_ONES);
        send_list_op(ilse_pkg::OP_READ, 4'd0, WORD_ZERO);
        send_list_op(ilse_pkg::OP_ERASE_AT, 4'd7, WORD_ZERO);    // middle
        send_list_op(ilse_pkg::OP_ERASE_FRONT, 4'd0, WORD_ZERO);
        send_list_op(ilse_pkg::OP_ERASE_BACK, 4'd0, WORD_ZERO);
        send_list_op(ilse_pkg::OP_READ_FRONT, 4'd0, WORD_ZERO);
        send_list_op(OP_SPARE_FIRST, 4'd0, WORD_ZERO);           // ignored, list not empty
        send_list_op(ilse_pkg::OP_CLEAR, 4'd0, WORD_ZERO);
    endtask

    // Long random run; the list swings between empty and full.
    task automatic test_random_traffic();
        int                         phase;
        int                         n;
        logic [ilse_pkg::OP_W-1:0]  opc;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_idling(phase);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (grow_mode && shadow_count == LIST_DEPTH && $urandom_range(0, 3) == 0)
                    grow_mode = 1'b0;
                else if (!grow_mode && shadow_count == 0 && $urandom_range(0, 3) == 0)
                    grow_mode = 1'b1;
                else if ($urandom_range(0, 49) == 0)
                    grow_mode = !grow_mode;
                opc = pick_list_op(grow_mode);
                send_list_op(opc, pick_index(opc), pick_word());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        op       = '0;
        index    = '0;
        value    = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_idling(3);
        test_empty_list();
        test_full_list();
        test_random_traffic();

        @(negedge clk);
        in_valid = 1'b0;
        // drain; the watchdog bounds this wait
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d items, checked %0d results; rejects: empty %0d, range %0d, full %0d",
                 items_sent, results_checked, reject_count[ilse_pkg::ST_EMPTY],
                 reject_count[ilse_pkg::ST_RANGE], reject_count[ilse_pkg::ST_FULL]);
        $display("Results at full capacity: %0d, under varied sender gaps and receiver stalls",
                 full_results);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
